// File: sv/mtcqf_pkg.sv
// ----------------------------------------------------------------------------
// MIDI time code quarter-frame codec package
// Operation codes, rate codes, quarter-frame piece numbers, field widths,
// range limits and the frame validity check.
// ----------------------------------------------------------------------------
`default_nettype none

package mtcqf_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned QfbW    = 7;
  localparam int unsigned PieceW  = 3;
  localparam int unsigned NibW    = 4;
  localparam int unsigned RateW   = 2;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned FrmW    = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_RECV = 2'd0,
    FUNC_EMIT = 2'd1,
    FUNC_LOAD = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [RateW-1:0] {
    RATE_24   = 2'd0,
    RATE_25   = 2'd1,
    RATE_30DF = 2'd2,
    RATE_30   = 2'd3
  } rate_e;

  // Quarter-frame piece numbers
  localparam logic [PieceW-1:0] PIECE_FRM_LO  = 3'd0;
  localparam logic [PieceW-1:0] PIECE_FRM_HI  = 3'd1;
  localparam logic [PieceW-1:0] PIECE_SEC_LO  = 3'd2;
  localparam logic [PieceW-1:0] PIECE_SEC_HI  = 3'd3;
  localparam logic [PieceW-1:0] PIECE_MIN_LO  = 3'd4;
  localparam logic [PieceW-1:0] PIECE_MIN_HI  = 3'd5;
  localparam logic [PieceW-1:0] PIECE_HOUR_LO = 3'd6;
  localparam logic [PieceW-1:0] PIECE_HOUR_HI = 3'd7;

  localparam logic [HourW-1:0] HOUR_MAX   = 5'd23;
  localparam logic [MinW-1:0]  MIN_MAX    = 6'd59;
  localparam logic [SecW-1:0]  SEC_MAX    = 6'd59;
  localparam logic [FrmW-1:0]  FRM_MAX_24 = 5'd23;
  localparam logic [FrmW-1:0]  FRM_MAX_25 = 5'd24;
  localparam logic [FrmW-1:0]  FRM_MAX_30 = 5'd29;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [FrmW-1:0]  frames;
  } frame_t;

  function automatic logic [FrmW-1:0] max_frame(input logic [RateW-1:0] rate);
    logic [FrmW-1:0] lim;
    case (rate_e'(rate))
      RATE_24: lim = FRM_MAX_24;
      RATE_25: lim = FRM_MAX_25;
      default: lim = FRM_MAX_30;
    endcase
    return lim;
  endfunction

  // Minute is a multiple of ten (six-bit range)
  function automatic logic min_tenth(input logic [MinW-1:0] mm);
    return (mm == 6'd0)  || (mm == 6'd10) || (mm == 6'd20) || (mm == 6'd30) ||
           (mm == 6'd40) || (mm == 6'd50) || (mm == 6'd60);
  endfunction

  function automatic logic time_ok(input frame_t f);
    logic dropped;
    dropped = (rate_e'(f.rate) == RATE_30DF) && (f.seconds == '0) &&
              !min_tenth(f.minutes) && (f.frames <= 5'd1);
    return (f.hours <= HOUR_MAX) && (f.minutes <= MIN_MAX) &&
           (f.seconds <= SEC_MAX) && (f.frames <= max_frame(f.rate)) && !dropped;
  endfunction

endpackage

`default_nettype wire

// File: sv/midi_timecode_quarter_frame_codec_unit.sv
// ----------------------------------------------------------------------------
// MIDI time code quarter-frame codec
// Holds one full time code frame; merges or emits quarter frames, or loads a whole frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one operation per
//   transaction: receive a quarter-frame byte, emit the byte for a piece,
//   load a whole frame, or do nothing. Output channel (out_valid_o /
//   out_ready_i) returns exactly one result per input transaction: the
//   stored frame after the operation, the validity flag, and the built
//   quarter-frame byte (zero unless the operation is an emit).
//   An input register captures the transaction, and the frame registers
//   and the result register are then updated from it.
//   Throughput is one transaction per cycle unless the receiver stalls;
//   the frame update is a single masked write plus a few compares, so nothing iterates.
//   When the receiver stalls, the result register holds and the input
//   register can still take one more transaction; only then does
//   in_ready_o drop.
//   Reset clears the frame to zero (24 fps, 00:00:00:00) and empties both
//   stages.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_timecode_quarter_frame_codec_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mtcqf_pkg::FuncW-1:0]  func_i,
  input  wire logic [mtcqf_pkg::QfbW-1:0]   quarter_frame_byte_i,
  input  wire logic [mtcqf_pkg::PieceW-1:0] piece_index_i,
  input  wire logic [mtcqf_pkg::RateW-1:0]  load_rate_i,
  input  wire logic [mtcqf_pkg::HourW-1:0]  load_hours_i,
  input  wire logic [mtcqf_pkg::MinW-1:0]   load_minutes_i,
  input  wire logic [mtcqf_pkg::SecW-1:0]   load_seconds_i,
  input  wire logic [mtcqf_pkg::FrmW-1:0]   load_frames_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mtcqf_pkg::RateW-1:0]       rate_code_o,
  output logic [mtcqf_pkg::HourW-1:0]       hours_o,
  output logic [mtcqf_pkg::MinW-1:0]        minutes_o,
  output logic [mtcqf_pkg::SecW-1:0]        seconds_o,
  output logic [mtcqf_pkg::FrmW-1:0]        frames_o,
  output logic                             time_valid_o,
  output logic [mtcqf_pkg::QfbW-1:0]        quarter_frame_out_o
);
  import mtcqf_pkg::*;

  // Input stage
  logic              s1_valid_q;
  logic [FuncW-1:0]  s1_func_q;
  logic [QfbW-1:0]   s1_qfb_q;
  logic [PieceW-1:0] s1_piece_q;
  frame_t            s1_load_q;

  // Stored frame
  frame_t frame_q, frame_d;

  // Result stage
  logic              out_valid_q;
  frame_t            res_frame_q;
  logic              res_ok_q, res_ok_d;
  logic [QfbW-1:0]   res_qfb_q, res_qfb_d;

  logic s1_advance;
  logic in_fire;

  // Input stage moves on when the result register is free or being drained
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q         <= func_i;
      s1_qfb_q          <= quarter_frame_byte_i;
      s1_piece_q        <= piece_index_i;
      s1_load_q.rate    <= load_rate_i;
      s1_load_q.hours   <= load_hours_i;
      s1_load_q.minutes <= load_minutes_i;
      s1_load_q.seconds <= load_seconds_i;
      s1_load_q.frames  <= load_frames_i;
    end
  end

  // Frame update and quarter-frame build
  logic [PieceW-1:0] rx_piece;
  logic [NibW-1:0]   rx_nib;
  logic [NibW-1:0]   tx_nib;

  assign rx_piece = s1_qfb_q[QfbW-1:NibW];
  assign rx_nib   = s1_qfb_q[NibW-1:0];

  always_comb begin
    frame_d   = frame_q;
    tx_nib    = '0;
    res_qfb_d = '0;
    case (func_e'(s1_func_q))
      FUNC_RECV: begin
        // Merge the nibble into the field selected by the piece number;
        // upper pieces keep only the bits the field has
        case (rx_piece)
          PIECE_FRM_LO:  frame_d.frames[3:0]  = rx_nib;
          PIECE_FRM_HI:  frame_d.frames[4]    = rx_nib[0];
          PIECE_SEC_LO:  frame_d.seconds[3:0] = rx_nib;
          PIECE_SEC_HI:  frame_d.seconds[5:4] = rx_nib[1:0];
          PIECE_MIN_LO:  frame_d.minutes[3:0] = rx_nib;
          PIECE_MIN_HI:  frame_d.minutes[5:4] = rx_nib[1:0];
          PIECE_HOUR_LO: frame_d.hours[3:0]   = rx_nib;
          PIECE_HOUR_HI: {frame_d.rate, frame_d.hours[4]} = rx_nib[2:0];
          default:       frame_d = frame_q;
        endcase
      end
      FUNC_EMIT: begin
        case (s1_piece_q)
          PIECE_FRM_LO:  tx_nib = frame_q.frames[3:0];
          PIECE_FRM_HI:  tx_nib = {3'b000, frame_q.frames[4]};
          PIECE_SEC_LO:  tx_nib = frame_q.seconds[3:0];
          PIECE_SEC_HI:  tx_nib = {2'b00, frame_q.seconds[5:4]};
          PIECE_MIN_LO:  tx_nib = frame_q.minutes[3:0];
          PIECE_MIN_HI:  tx_nib = {2'b00, frame_q.minutes[5:4]};
          PIECE_HOUR_LO: tx_nib = frame_q.hours[3:0];
          PIECE_HOUR_HI: tx_nib = {1'b0, frame_q.rate, frame_q.hours[4]};
          default:       tx_nib = '0;
        endcase
        res_qfb_d = {s1_piece_q, tx_nib};
      end
      FUNC_LOAD: frame_d = s1_load_q;
      default:   frame_d = frame_q;
    endcase
  end

  assign res_ok_d = time_ok(frame_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_advance) begin
        frame_q <= frame_d;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      res_frame_q <= frame_d;
      res_ok_q    <= res_ok_d;
      res_qfb_q   <= res_qfb_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign rate_code_o         = res_frame_q.rate;
  assign hours_o             = res_frame_q.hours;
  assign minutes_o           = res_frame_q.minutes;
  assign seconds_o           = res_frame_q.seconds;
  assign frames_o            = res_frame_q.frames;
  assign time_valid_o        = res_ok_q;
  assign quarter_frame_out_o = res_qfb_q;

endmodule

`default_nettype wire

// File: sv/mtcqf_checker.sv
// ----------------------------------------------------------------------------
// MIDI time code quarter-frame codec checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtcqf_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [mtcqf_pkg::RateW-1:0]  rate_code_o,
  input wire logic [mtcqf_pkg::HourW-1:0]  hours_o,
  input wire logic [mtcqf_pkg::MinW-1:0]   minutes_o,
  input wire logic [mtcqf_pkg::SecW-1:0]   seconds_o,
  input wire logic [mtcqf_pkg::FrmW-1:0]   frames_o,
  input wire logic                        time_valid_o,
  input wire logic [mtcqf_pkg::QfbW-1:0]   quarter_frame_out_o
);
  import mtcqf_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quarter_frame_out_o) &&
      $stable(frames_o) && $stable(time_valid_o))
    else $error("stalled result changed");

  // A valid time never exceeds the field ranges
  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_valid_o |-> hours_o <= HOUR_MAX && minutes_o <= MIN_MAX &&
      seconds_o <= SEC_MAX && frames_o <= FRM_MAX_30)
    else $error("time_valid set on out-of-range time");

  // Frame limit follows the rate code at 24 fps
  a_rate_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && time_valid_o && (rate_code_o == RATE_24) |-> frames_o <= FRM_MAX_24)
    else $error("24 fps frame above limit reported valid");

  // Dropped 29.97 frames at minute one are rejected
  a_drop_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rate_code_o == RATE_30DF) && (seconds_o == '0) &&
      (minutes_o == 6'd1) && (frames_o <= 5'd1) |-> !time_valid_o)
    else $error("dropped frame reported valid");

endmodule

bind midi_timecode_quarter_frame_codec_unit mtcqf_checker u_mtcqf_checker (.*);

`default_nettype wire

// File: bench/tb_midi_timecode_quarter_frame_codec_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the MIDI time code quarter-frame codec
// Drives receive, emit, load and no-op transactions through the valid/ready
// input channel and checks every result against an in-bench frame predictor.
// Directed corner cases come first, then full quarter-frame sequences with
// random time codes, then a random mix. Both sides idle at random, and the
// receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------

module tb_midi_timecode_quarter_frame_codec_unit;
  import mtcqf_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReports  = 60;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles  = 80;

  // Frame store indexes; bits 2..1 of a piece number select one directly
  localparam int unsigned StoreFrm      = 0;
  localparam int unsigned StoreSec      = 1;
  localparam int unsigned StoreMin      = 2;
  localparam int unsigned StoreRateHour = 3;

  // Bits of the addressed store that each piece covers
  localparam logic [7:0] MaskLoNib      = 8'h0F;
  localparam logic [7:0] MaskFrmHi      = 8'h10;
  localparam logic [7:0] MaskMinSecHi   = 8'h30;
  localparam logic [7:0] MaskRateHourHi = 8'h70;

  typedef struct packed {
    func_e             op;
    logic [QfbW-1:0]   qf_byte;
    logic [PieceW-1:0] piece;
    logic [RateW-1:0]  rate;
    logic [HourW-1:0]  hh;
    logic [MinW-1:0]   mm;
    logic [SecW-1:0]   ss;
    logic [FrmW-1:0]   ff;
  } mtc_txn_t;

  typedef struct packed {
    logic [RateW-1:0] rate;
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic [FrmW-1:0]  frames;
    logic             tvalid;
    logic [QfbW-1:0]  qf_out;
  } mtc_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid_i;
  logic              in_ready_o;
  logic [FuncW-1:0]  func_i;
  logic [QfbW-1:0]   quarter_frame_byte_i;
  logic [PieceW-1:0] piece_index_i;
  logic [RateW-1:0]  load_rate_i;
  logic [HourW-1:0]  load_hours_i;
  logic [MinW-1:0]   load_minutes_i;
  logic [SecW-1:0]   load_seconds_i;
  logic [FrmW-1:0]   load_frames_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [RateW-1:0]  rate_code_o;
  logic [HourW-1:0]  hours_o;
  logic [MinW-1:0]   minutes_o;
  logic [SecW-1:0]   seconds_o;
  logic [FrmW-1:0]   frames_o;
  logic              time_valid_o;
  logic [QfbW-1:0]   quarter_frame_out_o;

  // Predicted frame registers, one byte per store index
  logic [7:0]  tc_store [4];
  mtc_result_t expected_frames [$];

  int unsigned error_count  = 0;
  int unsigned report_count = 0;
  int unsigned cycle_count  = 0;
  int unsigned results_seen = 0;
  int unsigned invalid_seen = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};

  bit          tx_idle_on  = 1'b0;
  bit          rx_idle_on  = 1'b0;
  int unsigned rx_hold_req = 0;

  midi_timecode_quarter_frame_codec_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .func_i               (func_i),
    .quarter_frame_byte_i (quarter_frame_byte_i),
    .piece_index_i        (piece_index_i),
    .load_rate_i          (load_rate_i),
    .load_hours_i         (load_hours_i),
    .load_minutes_i       (load_minutes_i),
    .load_seconds_i       (load_seconds_i),
    .load_frames_i        (load_frames_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .rate_code_o          (rate_code_o),
    .hours_o              (hours_o),
    .minutes_o            (minutes_o),
    .seconds_o            (seconds_o),
    .frames_o             (frames_o),
    .time_valid_o         (time_valid_o),
    .quarter_frame_out_o  (quarter_frame_out_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] piece_mask(input logic [PieceW-1:0] piece);
    case (piece)
      PIECE_FRM_HI:                 return MaskFrmHi;
      PIECE_SEC_HI, PIECE_MIN_HI:   return MaskMinSecHi;
      PIECE_HOUR_HI:                return MaskRateHourHi;
      default:                      return MaskLoNib;
    endcase
  endfunction

  // Apply one transaction to the predicted frame and build its result
  function automatic mtc_result_t advance_timecode(input mtc_txn_t t);
    mtc_result_t      r;
    logic [PieceW-1:0] pc;
    logic [7:0]       mask;
    logic [7:0]       val;
    logic [FrmW-1:0]  lim;
    logic             dropped;
    r = '0;
    case (t.op)
      FUNC_RECV: begin
        // Upper pieces shift the nibble up; the mask drops bits past the field
        pc   = t.qf_byte[6:4];
        mask = piece_mask(pc);
        val  = {4'h0, t.qf_byte[3:0]};
        if (pc[0]) val = val << 4;
        tc_store[pc[2:1]] = (tc_store[pc[2:1]] & ~mask) | (val & mask);
      end
      FUNC_EMIT: begin
        pc  = t.piece;
        val = tc_store[pc[2:1]] & piece_mask(pc);
        if (pc[0]) val = val >> 4;
        r.qf_out = {pc, val[3:0]};
      end
      FUNC_LOAD: begin
        tc_store[StoreRateHour] = {1'b0, t.rate, t.hh};
        tc_store[StoreMin]      = {2'b00, t.mm};
        tc_store[StoreSec]      = {2'b00, t.ss};
        tc_store[StoreFrm]      = {3'b000, t.ff};
      end
      default: begin
      end
    endcase

    r.rate    = tc_store[StoreRateHour][6:5];
    r.hours   = tc_store[StoreRateHour][4:0];
    r.minutes = tc_store[StoreMin][5:0];
    r.seconds = tc_store[StoreSec][5:0];
    r.frames  = tc_store[StoreFrm][4:0];

    case (rate_e'(r.rate))
      RATE_24: lim = FRM_MAX_24;
      RATE_25: lim = FRM_MAX_25;
      default: lim = FRM_MAX_30;
    endcase
    // Drop-frame skips frames 0 and 1 at the top of minutes not divisible by ten
    dropped = (rate_e'(r.rate) == RATE_30DF) && (r.seconds == 0) &&
              ((r.minutes % 10) != 0) && (r.frames <= 1);
    r.tvalid = (r.hours <= HOUR_MAX) && (r.minutes <= MIN_MAX) &&
               (r.seconds <= SEC_MAX) && (r.frames <= lim) && !dropped;
    return r;
  endfunction

  // Every field random, every func code possible
  function automatic mtc_txn_t rand_op();
    mtc_txn_t t;
    t.op      = func_e'($urandom_range(0, 3));
    t.qf_byte = QfbW'($urandom_range(0, 127));
    t.piece   = PieceW'($urandom_range(0, 7));
    t.rate    = RateW'($urandom_range(0, 3));
    t.hh      = HourW'($urandom_range(0, 31));
    t.mm      = MinW'($urandom_range(0, 63));
    t.ss      = SecW'($urandom_range(0, 63));
    t.ff      = FrmW'($urandom_range(0, 31));
    return t;
  endfunction

  function automatic mtc_txn_t load_txn(input rate_e rate, input int unsigned hh,
                                        input int unsigned mm, input int unsigned ss,
                                        input int unsigned ff);
    mtc_txn_t t;
    t      = rand_op();
    t.op   = FUNC_LOAD;
    t.rate = rate;
    t.hh   = HourW'(hh);
    t.mm   = MinW'(mm);
    t.ss   = SecW'(ss);
    t.ff   = FrmW'(ff);
    return t;
  endfunction

  // Call at a falling edge; returns at a falling edge with valid possibly
  // still high, so the next transaction can follow back to back.
  task automatic send_item(input mtc_txn_t t);
    mtc_result_t r;
    int unsigned gap;
    func_i               = t.op;
    quarter_frame_byte_i = t.qf_byte;
    piece_index_i        = t.piece;
    load_rate_i          = t.rate;
    load_hours_i         = t.hh;
    load_minutes_i       = t.mm;
    load_seconds_i       = t.ss;
    load_frames_i        = t.ff;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = advance_timecode(t);
    expected_frames.push_back(r);
    op_count[t.op]++;
    if (!r.tvalid) invalid_seen++;
    @(negedge clk_i);
    gap = pick_gap(tx_idle_on);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_all_results();
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    mtc_txn_t t;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    // Reset frame reads back as 24 fps 00:00:00:00
    t = rand_op(); t.op = FUNC_EMIT; t.piece = PIECE_FRM_LO;  send_item(t);
    t = rand_op(); t.op = FUNC_EMIT; t.piece = PIECE_HOUR_HI; send_item(t);
    // Every load field at its top value; upper pieces must mask to field width
    send_item(load_txn(RATE_30, 31, 63, 63, 31));
    t = rand_op(); t.op = FUNC_EMIT; t.piece = PIECE_FRM_HI;  send_item(t);
    t = rand_op(); t.op = FUNC_EMIT; t.piece = PIECE_SEC_HI;  send_item(t);
    t = rand_op(); t.op = FUNC_EMIT; t.piece = PIECE_HOUR_HI; send_item(t);
    // Receive with nibble bits past the field set, then the unused code
    t = rand_op(); t.op = FUNC_RECV; t.qf_byte = {PIECE_FRM_LO, 4'h0};  send_item(t);
    t = rand_op(); t.op = FUNC_RECV; t.qf_byte = {PIECE_FRM_HI, 4'hE};  send_item(t);
    t = rand_op(); t.op = FUNC_RECV; t.qf_byte = {PIECE_HOUR_HI, 4'hF}; send_item(t);
    t = rand_op(); t.op = FUNC_NOP; send_item(t);
    // Range limits per rate, each just inside and just outside
    send_item(load_txn(RATE_24, 23, 59, 59, 23));
    send_item(load_txn(RATE_24, 0, 0, 0, 24));
    send_item(load_txn(RATE_25, 23, 59, 59, 24));
    send_item(load_txn(RATE_25, 0, 0, 0, 25));
    send_item(load_txn(RATE_30, 23, 59, 59, 29));
    send_item(load_txn(RATE_30, 0, 0, 0, 30));
    send_item(load_txn(RATE_24, 24, 0, 0, 0));
    send_item(load_txn(RATE_24, 0, 60, 60, 0));
    // Drop-frame: skipped frames, first kept frame, tenth minute, minute 60
    send_item(load_txn(RATE_30DF, 0, 1, 0, 0));
    send_item(load_txn(RATE_30DF, 0, 1, 0, 1));
    send_item(load_txn(RATE_30DF, 0, 1, 0, 2));
    send_item(load_txn(RATE_30DF, 0, 10, 0, 0));
    send_item(load_txn(RATE_30DF, 0, 60, 0, 0));
    wait_all_results();
  endtask

  // Receiver holds off while the sender keeps offering; the input must stall
  task automatic test_output_stall();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = HoldCycles;
    repeat (24) send_item(rand_op());
    wait_all_results();
  endtask

  // Eight-piece quarter-frame runs carrying random time codes, forward and
  // backward, some broken, some followed by a read-back of every piece
  task automatic test_frame_sequences(input int unsigned count);
    mtc_txn_t          t;
    logic [PieceW-1:0] pc;
    logic [7:0]        fields [4];
    logic [7:0]        hi;
    logic [3:0]        nib;
    logic [3:0]        junk;
    logic [1:0]        mode;
    int unsigned       rate, hh, mm, ss, ff, cut;
    bit                backward, broken;
    for (int unsigned s = 0; s < count; s++) begin
      // Idling stays fixed for stretches of ten runs
      mode       = 2'((s / 10) % 4);
      tx_idle_on = mode[0];
      rx_idle_on = mode[1];

      rate = $urandom_range(0, 3);
      hh   = $urandom_range(0, 23);
      mm   = $urandom_range(0, 59);
      ss   = $urandom_range(0, 59);
      case (rate_e'(rate))
        RATE_24: ff = $urandom_range(0, FRM_MAX_24);
        RATE_25: ff = $urandom_range(0, FRM_MAX_25);
        default: ff = $urandom_range(0, FRM_MAX_30);
      endcase
      // Aim at the drop-frame boundary
      if (rate_e'(rate) == RATE_30DF && $urandom_range(0, 2) == 0) begin
        ss = 0;
        ff = $urandom_range(0, 2);
      end
      // Out-of-range content now and then
      if ($urandom_range(0, 9) == 0) begin
        hh = $urandom_range(0, 31);
        mm = $urandom_range(0, 63);
        ss = $urandom_range(0, 63);
        ff = $urandom_range(0, 31);
      end
      fields[StoreFrm]      = 8'(ff);
      fields[StoreSec]      = 8'(ss);
      fields[StoreMin]      = 8'(mm);
      fields[StoreRateHour] = {1'b0, 2'(rate), 5'(hh)};

      backward = $urandom_range(0, 1);
      broken   = ($urandom_range(0, 7) == 0);
      cut      = $urandom_range(0, 7);

      for (int unsigned k = 0; k < 8; k++) begin
        pc = backward ? PieceW'(7 - k) : PieceW'(k);
        // Pause mid-run until the block has drained
        if (s % 13 == 6 && k == 4) wait_all_results();
        if (broken && k == cut) begin
          send_item(rand_op());
        end else begin
          hi   = fields[pc[2:1]] >> 4;
          junk = 4'($urandom_range(0, 15));
          case (pc)
            PIECE_FRM_HI:               nib = {junk[3:1], hi[0]};
            PIECE_SEC_HI, PIECE_MIN_HI: nib = {junk[3:2], hi[1:0]};
            PIECE_HOUR_HI:              nib = {junk[3], hi[2:0]};
            default:                    nib = fields[pc[2:1]][3:0];
          endcase
          t = rand_op();
          t.op      = FUNC_RECV;
          t.qf_byte = {pc, nib};
          send_item(t);
        end
      end

      if ($urandom_range(0, 1) == 1) begin
        for (int unsigned k = 0; k < 8; k++) begin
          t = rand_op();
          t.op    = FUNC_EMIT;
          t.piece = PieceW'(k);
          send_item(t);
        end
      end
    end
    wait_all_results();
  endtask

  task automatic test_random_mix(input int unsigned count);
    mtc_txn_t    t;
    int unsigned roll;
    logic [1:0]  mode;
    for (int unsigned i = 0; i < count; i++) begin
      mode       = 2'((i / 50) % 4);
      tx_idle_on = mode[1];
      rx_idle_on = mode[0];
      t    = rand_op();
      roll = $urandom_range(0, 9);
      if (roll < 4)       t.op = FUNC_RECV;
      else if (roll < 7)  t.op = FUNC_EMIT;
      else if (roll < 9)  t.op = FUNC_LOAD;
      else                t.op = FUNC_NOP;
      send_item(t);
    end
    wait_all_results();
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      if (report_count < MaxReports)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      else if (report_count == MaxReports)
        $display("%0t: further mismatches not shown", $time);
      report_count++;
    end
  endtask

  // Match each result transaction against the oldest prediction
  always @(posedge clk_i) begin : result_check
    mtc_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected: expected none, actual %0d:%0d:%0d:%0d",
                 $time, hours_o, minutes_o, seconds_o, frames_o);
      end else begin
        want = expected_frames.pop_front();
        compare_field("rate_code", 8'(want.rate), 8'(rate_code_o));
        compare_field("hours", 8'(want.hours), 8'(hours_o));
        compare_field("minutes", 8'(want.minutes), 8'(minutes_o));
        compare_field("seconds", 8'(want.seconds), 8'(seconds_o));
        compare_field("frames", 8'(want.frames), 8'(frames_o));
        compare_field("time_valid", 8'(want.tvalid), 8'(time_valid_o));
        compare_field("quarter_frame_out", 8'(want.qf_out), 8'(quarter_frame_out_o));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left  = pick_gap(rx_idle_on);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_frames.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : test_sequence
    in_valid_i           = 1'b0;
    func_i               = FUNC_RECV;
    quarter_frame_byte_i = '0;
    piece_index_i        = '0;
    load_rate_i          = '0;
    load_hours_i         = '0;
    load_minutes_i       = '0;
    load_seconds_i       = '0;
    load_frames_i        = '0;
    for (int i = 0; i < 4; i++) tc_store[i] = 8'h00;

    // Hold reset, then release it on a falling edge
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_output_stall();
    test_frame_sequences(90);
    test_random_mix(220);
    test_output_stall();

    wait_all_results();
    repeat (SettleCycles) @(negedge clk_i);

    $display("Covered %0d transactions: %0d receive, %0d emit, %0d load, %0d unused code",
             op_count[FUNC_RECV] + op_count[FUNC_EMIT] + op_count[FUNC_LOAD] +
             op_count[FUNC_NOP], op_count[FUNC_RECV], op_count[FUNC_EMIT],
             op_count[FUNC_LOAD], op_count[FUNC_NOP]);
    $display("Checked %0d results, %0d with an invalid time code; %0d mismatches",
             results_seen, invalid_seen, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/mtcqf_pkg.sv
sv/midi_timecode_quarter_frame_codec_unit.sv
sv/mtcqf_checker.sv
bench/tb_midi_timecode_quarter_frame_codec_unit.sv
